FILE: hw/rtl/multi_header_frame_parser_defines.svh
// assertion helpers for the frame parser
// each macro expects clk and rst_n in the using scope
`ifndef MULTI_HEADER_FRAME_PARSER_DEFINES_SVH
`define MULTI_HEADER_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define MHFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

`define MHFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`else

`define MHFP_ASSERT_SAME(label, ante, cons)

`define MHFP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/mhfp_pkg.sv
`timescale 1ns / 1ps

package mhfp_pkg;

    localparam int unsigned RUN_LIMIT  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned LEN_W      = 5;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TYPE1_MARKS  = 3'd0,
        REG_TYPE2_MARKS  = 3'd1,
        REG_TYPE3_MARKS  = 3'd2,
        REG_TYPE1_LENGTH = 3'd3,
        REG_TYPE2_LENGTH = 3'd4,
        REG_TYPE3_LENGTH = 3'd5
    } cfg_reg_t;

    localparam logic [31:0] TYPE1_MARKS_RST = 32'hABBA_5556;
    localparam logic [31:0] TYPE2_MARKS_RST = 32'hCDDC_5758;
    localparam logic [31:0] TYPE3_MARKS_RST = 32'hEFFE_5354;
    localparam logic [LEN_W-1:0] TYPE1_LENGTH_RST = 5'd6;
    localparam logic [LEN_W-1:0] TYPE2_LENGTH_RST = 5'd13;
    localparam logic [LEN_W-1:0] TYPE3_LENGTH_RST = 5'd6;

    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_1    = 2'd1;
    localparam logic [1:0] TYPE_2    = 2'd2;
    localparam logic [1:0] TYPE_3    = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

endpackage

FILE: hw/rtl/mhfp_ram.sv
`timescale 1ns / 1ps

module mhfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/multi_header_frame_parser.sv
`timescale 1ns / 1ps

// Finds frames of three types in a received byte stream: two header bytes, a payload of
// per-type length, two trailer bytes. Each accepted byte that does not complete a frame
// gives one status word in the next cycle; the trailer byte that completes a frame gives
// the stored payload as a run of n words instead (n = effective length of the type,
// 1 to 16). For a completing byte, every payload word is read from the payload RAM in
// S_READ and then loaded into the output register in S_LOAD, which waits while the
// output word is held by out_stall. Input is taken only when the parser is idle and
// the output register is free or draining. Configuration is written through cfg_we,
// cfg_index and cfg_data; lengths use the low five bits.

`include "multi_header_frame_parser_defines.svh"

module multi_header_frame_parser #(
    parameter int unsigned MAX_PAYLOAD = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [mhfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mhfp_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               is_payload,
    output logic [1:0]                         frame_type,
    output logic [7:0]                         payload_byte,
    output logic [3:0]                         byte_index,
    output logic                               last,
    output logic [15:0]                        mismatch_count,
    output logic [1:0]                         parse_phase
);

    import mhfp_pkg::*;

    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] CAP =
        LEN_W'((MAX_PAYLOAD < RUN_LIMIT) ? MAX_PAYLOAD : RUN_LIMIT);

    function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
        begin
            r = LEN_W'(1);
        end
        else if (len > CAP)
        begin
            r = CAP;
        end
        return r;
    endfunction

    // configuration
    logic [31:0]      type1_marks_reg, type2_marks_reg, type3_marks_reg;
    logic [LEN_W-1:0] type1_length_reg, type2_length_reg, type3_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type1_marks_reg  <= TYPE1_MARKS_RST;
            type2_marks_reg  <= TYPE2_MARKS_RST;
            type3_marks_reg  <= TYPE3_MARKS_RST;
            type1_length_reg <= TYPE1_LENGTH_RST;
            type2_length_reg <= TYPE2_LENGTH_RST;
            type3_length_reg <= TYPE3_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TYPE1_MARKS:  type1_marks_reg  <= cfg_data;
                REG_TYPE2_MARKS:  type2_marks_reg  <= cfg_data;
                REG_TYPE3_MARKS:  type3_marks_reg  <= cfg_data;
                REG_TYPE1_LENGTH: type1_length_reg <= cfg_data[LEN_W-1:0];
                REG_TYPE2_LENGTH: type2_length_reg <= cfg_data[LEN_W-1:0];
                REG_TYPE3_LENGTH: type3_length_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // parser state
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [1:0]       type_reg, type_next;
    logic [15:0]      miss_reg, miss_next;

    state_t           state_reg, state_next;
    logic [3:0]       rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [1:0]       run_type_reg, run_type_next;

    logic             out_valid_reg, out_valid_next;
    logic             is_payload_reg, is_payload_next;
    logic [1:0]       frame_type_reg, frame_type_next;
    logic [7:0]       payload_byte_reg, payload_byte_next;
    logic [3:0]       byte_index_reg, byte_index_next;
    logic             last_reg, last_next;
    logic [15:0]      mismatch_reg, mismatch_next;
    logic [1:0]       phase_out_reg, phase_out_next;

    logic             out_free;
    logic             accept;
    logic             frame_done;
    logic             mem_we;
    logic             mem_re;
    logic [7:0]       mem_rdata;
    logic [31:0]      cur_marks;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] pos_inc;
    logic [7:0]       trailer_mark;
    logic             run_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign pos_inc  = pos_reg + LEN_W'(1);
    assign run_last = ({1'b0, rd_idx_reg} + LEN_W'(1)) == run_len_reg;

    always_comb
    begin
        case (type_reg)
            TYPE_1:  cur_marks = type1_marks_reg;
            TYPE_2:  cur_marks = type2_marks_reg;
            default: cur_marks = type3_marks_reg;
        endcase
        case (type_reg)
            TYPE_1:  cur_len = clip_len(type1_length_reg);
            TYPE_2:  cur_len = clip_len(type2_length_reg);
            default: cur_len = clip_len(type3_length_reg);
        endcase
    end

    assign trailer_mark = pos_reg[0] ? cur_marks[7:0] : cur_marks[15:8];

    // one step of the header / payload / trailer walk
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        type_next  = type_reg;
        miss_next  = miss_reg;
        mem_we     = 1'b0;
        frame_done = 1'b0;
        if (phase_reg == PH_PAYLOAD && type_reg != TYPE_NONE)
        begin
            mem_we = accept && (int'(pos_reg) < MAX_PAYLOAD);
            if (pos_inc >= cur_len)
            begin
                phase_next = PH_TRAILER;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
        else if (phase_reg == PH_TRAILER && type_reg != TYPE_NONE)
        begin
            if (rx_byte != trailer_mark)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                type_next  = TYPE_NONE;
                miss_next  = miss_reg + 16'd1;
            end
            else if (pos_reg != '0)
            begin
                frame_done = 1'b1;
                phase_next = PH_HEADER;
                pos_next   = '0;
                type_next  = TYPE_NONE;
                miss_next  = '0;
            end
            else
            begin
                pos_next = LEN_W'(1);
            end
        end
        else if (phase_reg == PH_HEADER && pos_reg == LEN_W'(1) && type_reg != TYPE_NONE)
        begin
            if (rx_byte == cur_marks[23:16])
            begin
                phase_next = PH_PAYLOAD;
                pos_next   = '0;
            end
            else
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
                type_next  = TYPE_NONE;
                miss_next  = miss_reg + 16'd1;
            end
        end
        else
        begin
            // first header byte, lowest type wins on a shared byte
            phase_next = PH_HEADER;
            pos_next   = LEN_W'(1);
            if (rx_byte == type1_marks_reg[31:24])
            begin
                type_next = TYPE_1;
            end
            else if (rx_byte == type2_marks_reg[31:24])
            begin
                type_next = TYPE_2;
            end
            else if (rx_byte == type3_marks_reg[31:24])
            begin
                type_next = TYPE_3;
            end
            else
            begin
                type_next = TYPE_NONE;
                pos_next  = '0;
                miss_next = miss_reg + 16'd1;
            end
        end
    end

    // sequencer and output register
    always_comb
    begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        run_len_next      = run_len_reg;
        run_type_next     = run_type_reg;
        mem_re            = 1'b0;
        out_valid_next    = out_valid_reg && out_stall;
        is_payload_next   = is_payload_reg;
        frame_type_next   = frame_type_reg;
        payload_byte_next = payload_byte_reg;
        byte_index_next   = byte_index_reg;
        last_next         = last_reg;
        mismatch_next     = mismatch_reg;
        phase_out_next    = phase_out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (frame_done)
                    begin
                        state_next    = S_READ;
                        rd_idx_next   = '0;
                        run_len_next  = cur_len;
                        run_type_next = type_reg;
                    end
                    else
                    begin
                        out_valid_next    = 1'b1;
                        is_payload_next   = 1'b0;
                        frame_type_next   = TYPE_NONE;
                        payload_byte_next = '0;
                        byte_index_next   = '0;
                        last_next         = 1'b1;
                        mismatch_next     = miss_next;
                        phase_out_next    = phase_next;
                    end
                end
            end
            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    is_payload_next   = 1'b1;
                    frame_type_next   = run_type_reg;
                    payload_byte_next = mem_rdata;
                    byte_index_next   = rd_idx_reg;
                    last_next         = run_last;
                    mismatch_next     = '0;
                    phase_out_next    = PH_HEADER;
                    rd_idx_next       = rd_idx_reg + 4'd1;
                    state_next        = run_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            type_reg      <= TYPE_NONE;
            miss_reg      <= '0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                type_reg  <= type_next;
                miss_reg  <= miss_next;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg       <= rd_idx_next;
        run_len_reg      <= run_len_next;
        run_type_reg     <= run_type_next;
        is_payload_reg   <= is_payload_next;
        frame_type_reg   <= frame_type_next;
        payload_byte_reg <= payload_byte_next;
        byte_index_reg   <= byte_index_next;
        last_reg         <= last_next;
        mismatch_reg     <= mismatch_next;
        phase_out_reg    <= phase_out_next;
    end

    mhfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_payload_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(pos_reg)),
        .wdata (rx_byte),
        .re    (mem_re),
        .raddr (AW'(rd_idx_reg)),
        .rdata (mem_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign is_payload     = is_payload_reg;
    assign frame_type     = frame_type_reg;
    assign payload_byte   = payload_byte_reg;
    assign byte_index     = byte_index_reg;
    assign last           = last_reg;
    assign mismatch_count = mismatch_reg;
    assign parse_phase    = phase_out_reg;

    // a completed frame starts a readout from entry zero with the count cleared
    `MHFP_ASSERT_NEXT(a_run_start, accept && frame_done, state_reg == S_READ && rd_idx_reg == '0)
    `MHFP_ASSERT_NEXT(a_run_count_clear, accept && frame_done, miss_reg == 16'd0)
    // payload words never index past the latched run length
    `MHFP_ASSERT_SAME(a_run_bound, out_valid && is_payload, LEN_W'(byte_index_reg) < run_len_reg)
    // no byte is taken while a readout is in flight
    `MHFP_ASSERT_SAME(a_no_take_in_run, state_reg == S_READ || state_reg == S_LOAD, !accept)

endmodule
